>>> hdl/epba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epba_pkg
// Shared constants, types and control structs for the ephemeral port
// bitmap allocator.
// ----------------------------------------------------------------------------
package epba_pkg;

    // Bitmap size in bytes, one bit per port.
    localparam int BITMAP_BYTES = 2048;
    localparam logic [15:0] PORT_BASE = 16'hC000;
    localparam logic [7:0]  FULL_BYTE = 8'hFF;

    // Bytes are grouped into summary words; one full flag per byte.
    localparam int LANES      = 32;
    localparam int LANE_W     = 5;
    localparam int GROUPS     = (BITMAP_BYTES + LANES - 1) / LANES;
    localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int BYTE_AW    = GRP_W + LANE_W;
    localparam int BYTE_DEPTH = GROUPS * LANES;

    // Byte index width carried by a 16-bit port above the base.
    localparam int IDX_W = 11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic clr_we;         // clearing pass write
        logic ld_in;          // capture accepted input word
        logic rd_l1_alloc;    // read summary word of first non-full group
        logic rd_byte_alloc;  // read first non-full byte of that group
        logic wr_alloc;       // set bit, update summaries, stage result
        logic rd_free;        // read byte and summary word to free
        logic wr_free;        // clear bit and summaries
        logic res_none;       // stage none-free result
        logic res_zero;       // stage zero result
        logic push;           // move staged result to output register
    } t_cmd;

    typedef struct packed {
        logic op_free;
        logic free_hit;
        logic all_full;
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage : epba_pkg
`default_nettype wire

>>> hdl/epba_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epba_in_if
// Request channel: operation and port, valid/ready handshake.
// ----------------------------------------------------------------------------
interface epba_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] port_in;

    modport source (output valid, output op, output port_in, input ready);
    modport sink   (input valid, input op, input port_in, output ready);
endinterface : epba_in_if
`default_nettype wire

>>> hdl/epba_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epba_out_if
// Response channel: allocated port and none-free flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface epba_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] port_out;
    logic        none_free;

    modport source (output valid, output port_out, output none_free, input ready);
    modport sink   (input valid, input port_out, input none_free, output ready);
endinterface : epba_out_if
`default_nettype wire

>>> hdl/ephemeral_port_bitmap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ephemeral_port_bitmap_allocator_top
// First-fit allocator over the ephemeral port range starting at 49152.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word fields              Handshake
//  i_in     in   op, port_in (net order)  valid/ready
//  o_out    out  port_out, none_free      valid/ready
//
//  After reset a clearing pass writes every bitmap byte and summary word;
//  no word is accepted meanwhile.
//  Allocate: group flops -> summary RAM read -> bitmap RAM read -> write
//  back. Free: bitmap and summary RAMs read together then written. Full or
//  out-of-range cases go straight to the result push.
//  The block takes one word at a time; a result waiting in the output
//  register does not stop the next word from being accepted, only its push.
//  Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module ephemeral_port_bitmap_allocator_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    epba_in_if.sink    i_in,
    epba_out_if.source o_out
);
    import epba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: owns the input ready and drives datapath steps
    epba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, search and result register
    epba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_in.op),
        .i_port_in   (i_in.port_in),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_port_out  (o_out.port_out),
        .o_none_free (o_out.none_free)
    );

endmodule : ephemeral_port_bitmap_allocator_top
`default_nettype wire

>>> hdl/epba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epba_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module epba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                           i_wdata,
    input  wire                                       i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule : epba_ram
`default_nettype wire

>>> hdl/epba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epba_ctrl
// Sequencer: clearing pass, allocate/free read-modify-write steps, result push.
// ----------------------------------------------------------------------------
module epba_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  epba_pkg::t_sts i_sts,
    output epba_pkg::t_cmd o_cmd
);
    import epba_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DISP   = 3'd2;
    localparam logic [2:0] ST_A_L1   = 3'd3;
    localparam logic [2:0] ST_A_BYTE = 3'd4;
    localparam logic [2:0] ST_F_RMW  = 3'd5;
    localparam logic [2:0] ST_PUSH   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.op_free) begin
                    o_cmd.res_zero = 1'b1;
                    if (i_sts.free_hit) begin
                        o_cmd.rd_free = 1'b1;
                        n_state       = ST_F_RMW;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end else if (i_sts.all_full) begin
                    o_cmd.res_none = 1'b1;
                    n_state        = ST_PUSH;
                end else begin
                    o_cmd.rd_l1_alloc = 1'b1;
                    n_state           = ST_A_L1;
                end
            end
            ST_A_L1: begin
                o_cmd.rd_byte_alloc = 1'b1;
                n_state             = ST_A_BYTE;
            end
            ST_A_BYTE: begin
                o_cmd.wr_alloc = 1'b1;
                n_state        = ST_PUSH;
            end
            ST_F_RMW: begin
                o_cmd.wr_free = 1'b1;
                n_state       = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_byte_after_l1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_A_BYTE) |-> ($past(r_state) == ST_A_L1))
        else $error("byte step not preceded by summary read");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
        else $error("clearing pass re-entered");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_state == ST_IDLE))
        else $error("push did not return to idle");

endmodule : epba_ctrl
`default_nettype wire

>>> hdl/epba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epba_dp
// Datapath: bitmap RAM, per-byte full-flag RAM, per-group full flops,
// priority encoders, result staging and output register.
// ----------------------------------------------------------------------------
module epba_dp (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  epba_pkg::t_cmd i_cmd,
    output epba_pkg::t_sts o_sts,
    input  wire            i_op,
    input  wire [15:0]     i_port_in,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output logic [15:0]    o_port_out,
    output logic           o_none_free
);
    import epba_pkg::*;

    // input decode
    logic [15:0]      host_in;
    logic [IDX_W-1:0] in_idx;
    logic             in_hit;

    logic             r_op;
    logic             r_hit;
    logic [GRP_W-1:0] r_grp;
    logic [LANE_W-1:0] r_lane;
    logic [2:0]       r_bit;

    logic [GROUPS-1:0] r_grp_full;
    logic [BYTE_AW-1:0] r_sweep;

    logic [15:0] r_res_port;
    logic        r_res_none;
    logic        r_ov;
    logic [15:0] r_out_port;
    logic        r_out_none;

    // RAM ports
    logic              bm_we, bm_re;
    logic [BYTE_AW-1:0] bm_waddr, bm_raddr;
    logic [7:0]        bm_wdata, bm_rdata;
    logic              l1_we, l1_re;
    logic [GRP_W-1:0]  l1_waddr, l1_raddr;
    logic [LANES-1:0]  l1_wdata, l1_rdata;

    // encoders and derived values
    logic [GRP_W-1:0]  grp_enc;
    logic [LANE_W-1:0] lane_enc;
    logic [2:0]        bit_enc;
    logic [LANES-1:0]  pad_mask;
    logic [7:0]        byte_set;
    logic [LANES-1:0]  l1_set;
    logic [LANES-1:0]  lane_oh;
    logic [15:0]       alloc_host;

    assign host_in = {i_port_in[7:0], i_port_in[15:8]};
    assign in_idx  = host_in[IDX_W+2:3];
    assign in_hit  = (host_in[15:14] == PORT_BASE[15:14])
                   && ({1'b0, in_idx} < (IDX_W+1)'(BITMAP_BYTES));

    always_comb begin
        grp_enc = '0;
        for (int i = GROUPS - 1; i >= 0; i--) begin
            if (!r_grp_full[i]) begin
                grp_enc = GRP_W'(i);
            end
        end
    end

    always_comb begin
        lane_enc = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (!l1_rdata[i]) begin
                lane_enc = LANE_W'(i);
            end
        end
    end

    always_comb begin
        bit_enc = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!bm_rdata[i]) begin
                bit_enc = 3'(i);
            end
        end
    end

    // bytes beyond the bitmap in the last group start out marked full
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            pad_mask[l] = ((int'(r_sweep[BYTE_AW-1:LANE_W]) * LANES + l) >= BITMAP_BYTES);
        end
    end

    assign lane_oh    = LANES'(1) << r_lane;
    assign byte_set   = bm_rdata | (8'd1 << bit_enc);
    assign l1_set     = l1_rdata | lane_oh;
    assign alloc_host = PORT_BASE | 16'({r_grp, r_lane, bit_enc});

    // bitmap RAM port selection
    always_comb begin
        bm_re    = i_cmd.rd_byte_alloc | i_cmd.rd_free;
        bm_raddr = i_cmd.rd_byte_alloc ? {r_grp, lane_enc} : {r_grp, r_lane};
        bm_we    = i_cmd.clr_we | i_cmd.wr_alloc | i_cmd.wr_free;
        bm_waddr = i_cmd.clr_we ? r_sweep : {r_grp, r_lane};
        if (i_cmd.clr_we) begin
            bm_wdata = '0;
        end else if (i_cmd.wr_alloc) begin
            bm_wdata = byte_set;
        end else begin
            bm_wdata = bm_rdata & ~(8'd1 << r_bit);
        end
    end

    // full-flag RAM port selection
    always_comb begin
        l1_re    = i_cmd.rd_l1_alloc | i_cmd.rd_free;
        l1_raddr = i_cmd.rd_l1_alloc ? grp_enc : r_grp;
        l1_we    = (i_cmd.clr_we && (r_sweep[LANE_W-1:0] == '0))
                 | (i_cmd.wr_alloc && (byte_set == FULL_BYTE))
                 | i_cmd.wr_free;
        l1_waddr = i_cmd.clr_we ? r_sweep[BYTE_AW-1:LANE_W] : r_grp;
        if (i_cmd.clr_we) begin
            l1_wdata = pad_mask;
        end else if (i_cmd.wr_alloc) begin
            l1_wdata = l1_set;
        end else begin
            l1_wdata = l1_rdata & ~lane_oh;
        end
    end

    epba_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    epba_ram #(.WIDTH(LANES), .DEPTH(GROUPS)) u_l1 (
        .i_clk   (i_clk),
        .i_we    (l1_we),
        .i_waddr (l1_waddr),
        .i_wdata (l1_wdata),
        .i_re    (l1_re),
        .i_raddr (l1_raddr),
        .o_rdata (l1_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_op   <= i_op;
            r_hit  <= in_hit;
            r_grp  <= in_idx[LANE_W +: GRP_W];
            r_lane <= in_idx[LANE_W-1:0];
            r_bit  <= host_in[2:0];
        end
        if (i_cmd.rd_l1_alloc) begin
            r_grp <= grp_enc;
        end
        if (i_cmd.rd_byte_alloc) begin
            r_lane <= lane_enc;
        end
        if (i_cmd.res_none) begin
            r_res_port <= '0;
            r_res_none <= 1'b1;
        end else if (i_cmd.res_zero) begin
            r_res_port <= '0;
            r_res_none <= 1'b0;
        end else if (i_cmd.wr_alloc) begin
            r_res_port <= {alloc_host[7:0], alloc_host[15:8]};
            r_res_none <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out_port <= r_res_port;
            r_out_none <= r_res_none;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_full <= '0;
            r_sweep    <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cmd.clr_we) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.wr_alloc && (byte_set == FULL_BYTE) && (&l1_set)) begin
                r_grp_full[r_grp] <= 1'b1;
            end else if (i_cmd.wr_free) begin
                r_grp_full[r_grp] <= 1'b0;
            end
            if (i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.op_free    = (r_op == OP_FREE);
    assign o_sts.free_hit   = r_hit;
    assign o_sts.all_full   = &r_grp_full;
    assign o_sts.sweep_last = (r_sweep == BYTE_AW'(BYTE_DEPTH - 1));
    assign o_sts.out_free   = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_port_out  = r_out_port;
    assign o_none_free = r_out_none;

    a_alloc_byte_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_alloc |-> (bm_rdata != FULL_BYTE))
        else $error("allocate picked a full byte");

    a_alloc_group_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_alloc |-> !(&l1_rdata))
        else $error("allocate picked a full group");

    a_no_output_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_we |-> !r_ov)
        else $error("output pending during clearing pass");

endmodule : epba_dp
`default_nettype wire

>>> verif/epba_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epba_alloc_checker
// Watches both channels of the port allocator, keeps a shadow copy of the
// port bitmap, predicts the answer to every accepted request word and checks
// each answer word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module epba_alloc_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    epba_in_if   i_req,
    epba_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_answers,
    output int   o_none_free_seen
);
    import epba_pkg::*;

    typedef struct packed {
        logic [15:0] port;
        logic        none_free;
    } t_answer;

    logic [7:0]  shadow_bitmap [BITMAP_BYTES];
    // every byte below this index is known to be full
    int unsigned first_open_byte;
    t_answer     expected_answers [$];

    int fail_tally      = 0;
    int answer_tally    = 0;
    int none_free_tally = 0;

    function automatic logic [15:0] swap_bytes(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // Applies one request to the shadow bitmap and returns its answer.
    function automatic t_answer predict_answer(input logic op, input logic [15:0] port_net);
        t_answer     ans;
        logic [15:0] host;
        logic [15:0] offset;
        int unsigned idx;
        bit          found;
        ans   = '0;
        found = 1'b0;
        if (op == OP_ALLOC) begin
            idx = first_open_byte;
            while (!found && idx < BITMAP_BYTES) begin
                if (shadow_bitmap[idx] != FULL_BYTE) begin
                    for (int b = 0; b < 8; b++) begin
                        if (!found && !shadow_bitmap[idx][b]) begin
                            shadow_bitmap[idx][b] = 1'b1;
                            host     = PORT_BASE + 16'(8 * idx + b);
                            ans.port = swap_bytes(host);
                            found    = 1'b1;
                        end
                    end
                end else begin
                    idx++;
                end
            end
            first_open_byte = idx;
            if (!found)
                ans.none_free = 1'b1;
        end else begin
            host = swap_bytes(port_net);
            if (host >= PORT_BASE) begin
                offset = host - PORT_BASE;
                idx    = offset >> 3;
                if (idx < BITMAP_BYTES) begin
                    shadow_bitmap[idx][offset[2:0]] = 1'b0;
                    if (idx < first_open_byte)
                        first_open_byte = idx;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int k = 0; k < BITMAP_BYTES; k++)
                shadow_bitmap[k] = '0;
            first_open_byte = 0;
            expected_answers.delete();
            o_pending <= 0;
        end else begin
            // answer first: it can never belong to a request taken at this edge
            if (i_rsp.valid && i_rsp.ready) begin
                answer_tally++;
                if (i_rsp.none_free)
                    none_free_tally++;
                if (expected_answers.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected answer port_out=%h none_free=%b",
                             $time, i_rsp.port_out, i_rsp.none_free);
                end else begin
                    want = expected_answers.pop_front();
                    if (i_rsp.port_out !== want.port) begin
                        fail_tally++;
                        $display("%0t: port_out expected %h actual %h",
                                 $time, want.port, i_rsp.port_out);
                    end
                    if (i_rsp.none_free !== want.none_free) begin
                        fail_tally++;
                        $display("%0t: none_free expected %b actual %b",
                                 $time, want.none_free, i_rsp.none_free);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                expected_answers.push_back(predict_answer(i_req.op, i_req.port_in));
            o_pending <= expected_answers.size();
        end
        o_fail_count     <= fail_tally;
        o_answers        <= answer_tally;
        o_none_free_seen <= none_free_tally;
    end

endmodule : epba_alloc_checker

>>> verif/tb_ephemeral_port_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ephemeral_port_bitmap_allocator_top
// Stimulus and verdict for the ephemeral port allocator: directed corner
// words, a run of allocates that packs the low groups solid, then a random
// mix of allocate and free words under changing idle and stall patterns.
// Checking is done by epba_alloc_checker alongside the block.
// ----------------------------------------------------------------------------
module tb_ephemeral_port_bitmap_allocator_top;
    import epba_pkg::*;

    // Cycles with no word moving on either channel before the run is
    // declared hung. Covers the clearing pass after reset plus any
    // plausible random stall run, with a wide margin.
    localparam int QUIET_LIMIT = 8000;

    // Enough allocates to fill the first couple of 256-port groups.
    localparam int FILL_WORDS   = 600;
    localparam int RANDOM_WORDS = 620;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    t_idle_mode idle_mode = IDLE_NONE;

    int words_sent = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int answers;
    int none_free_seen;

    epba_in_if  req_ch ();
    epba_out_if rsp_ch ();

    ephemeral_port_bitmap_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    epba_alloc_checker checker_u (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_ch),
        .i_rsp            (rsp_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_answers        (answers),
        .o_none_free_seen (none_free_seen)
    );

    always #2 i_clk = ~i_clk;

    // Percent of cycles in which the sender holds off / the receiver stalls.
    function automatic int send_idle_pct(input t_idle_mode m);
        case (m)
            IDLE_SEND: return 47;
            IDLE_BOTH: return 34;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input t_idle_mode m);
        case (m)
            IDLE_RECV: return 47;
            IDLE_BOTH: return 34;
            default:   return 0;
        endcase
    endfunction

    // Ports travel in network order: swap the two bytes of a host port.
    function automatic logic [15:0] net_order(input logic [15:0] host);
        return {host[7:0], host[15:8]};
    endfunction

    // Receiver side: ready rerolled every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_mode));
        end
    end

    // Watchdog: only counts cycles in which nothing is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Presents one request word and returns at the edge that accepts it.
    // A random hold-off may precede it; valid stays high between
    // back-to-back words so it never toggles within one step.
    task automatic send_word(input logic op, input logic [15:0] port_net);
        if ($urandom_range(0, 99) < send_idle_pct(idle_mode)) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct(idle_mode));
        end
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.port_in <= port_net;
        do @(posedge i_clk);
        while (!req_ch.ready);
        words_sent++;
    endtask

    // Stop sending and wait until every predicted answer has arrived.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk);
        while (pending != 0);
    endtask

    initial begin
        int          roll;
        logic [15:0] host;

        req_ch.valid   = 1'b0;
        req_ch.op      = OP_ALLOC;
        req_ch.port_in = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass runs now; the first word just waits for ready.

        // ---- directed corners, no idling ----
        send_word(OP_ALLOC, 16'h0000);             // first port of the range
        send_word(OP_ALLOC, 16'hFFFF);             // port_in ignored on allocate
        send_word(OP_ALLOC, 16'h5AA5);
        send_word(OP_FREE, net_order(16'd49153));  // punch a hole
        send_word(OP_ALLOC, 16'h0000);             // lowest clear bit is refilled
        send_word(OP_FREE, 16'h0000);              // host 0: below range
        send_word(OP_FREE, net_order(16'd49151));  // one below the base
        send_word(OP_FREE, net_order(16'h8000));   // below range, top bit set
        send_word(OP_FREE, net_order(16'hFFFF));   // last port, already free
        send_word(OP_FREE, net_order(16'd49152));
        send_word(OP_FREE, net_order(16'd49152));  // clearing a clear bit
        send_word(OP_ALLOC, 16'h0000);
        send_word(OP_FREE, 16'h00C0);              // 49152 given in net order
        send_word(OP_ALLOC, 16'h0000);
        send_word(OP_FREE, net_order(16'd49159));  // bit 7 of byte 0, free
        repeat (6) send_word(OP_ALLOC, 16'h0000);  // walk into byte 1

        // Sender holds off until the block has answered everything.
        wait_drained();

        // ---- pack the low groups solid ----
        for (int n = 0; n < FILL_WORDS; n++) begin
            if (n % (FILL_WORDS / 4) == 0)
                idle_mode <= t_idle_mode'((n / (FILL_WORDS / 4)) % 4);
            send_word(OP_ALLOC, 16'($urandom()));
        end

        // Frees far above the filled front, below range and at the last port.
        send_word(OP_FREE, net_order(16'd57152));
        send_word(OP_ALLOC, 16'h0000);
        send_word(OP_ALLOC, 16'h0000);
        send_word(OP_FREE, net_order(16'd1000));
        send_word(OP_ALLOC, 16'h0000);
        send_word(OP_FREE, net_order(16'hFFFF));
        send_word(OP_ALLOC, 16'h0000);             // still takes the lowest hole

        // ---- random mix over a dense bitmap ----
        // Mostly in-range frees and allocates so the first-fit search keeps
        // finding scattered holes; the rest is raw noise and low ports.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % (RANDOM_WORDS / 4) == 0)
                idle_mode <= t_idle_mode'((n / (RANDOM_WORDS / 4)) % 4);
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_word(OP_ALLOC, 16'($urandom()));
            end else if (roll < 80) begin
                if ($urandom_range(0, 1))
                    host = PORT_BASE + 16'($urandom_range(0, 511));
                else
                    host = PORT_BASE + 16'($urandom_range(0, 8 * BITMAP_BYTES - 1));
                send_word(OP_FREE, net_order(host));
            end else if (roll < 90) begin
                send_word(OP_FREE, 16'($urandom()));
            end else begin
                host = 16'($urandom_range(0, 49151));
                send_word(OP_FREE, net_order(host));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);  // catch any stray answer

        $display("Sent %0d request words: directed corners, a packed low range", words_sent);
        $display("and a random alloc/free mix; %0d answers checked, %0d none-free.",
                 answers, none_free_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule : tb_ephemeral_port_bitmap_allocator_top

>>> sim.f
hdl/epba_pkg.sv
hdl/epba_in_if.sv
hdl/epba_out_if.sv
hdl/epba_ram.sv
hdl/epba_ctrl.sv
hdl/epba_dp.sv
hdl/ephemeral_port_bitmap_allocator_top.sv
verif/epba_alloc_checker.sv
verif/tb_ephemeral_port_bitmap_allocator_top.sv
